[hdl/hps_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hps_pkg
// Shared types and constants for the HV precharge sequencer.
// ----------------------------------------------------------------------------
package hps_pkg;

  localparam int unsigned VOLT_W  = 16;
  localparam int unsigned MS_W    = 16;
  localparam int unsigned STEP_W  = 8;
  localparam int unsigned RATIO_W = 7;
  // 65535 * 127 still fits below 2**23
  localparam int unsigned PROD_W  = VOLT_W + RATIO_W;

  localparam logic [RATIO_W-1:0] PCT_SCALE = 7'd100;

  // Configuration register indexes
  localparam logic [1:0] CFG_MIN_MS    = 2'd0;
  localparam logic [1:0] CFG_MAX_MS    = 2'd1;
  localparam logic [1:0] CFG_RATIO_PCT = 2'd2;

  localparam logic [MS_W-1:0]    MIN_MS_RST = 16'd500;
  localparam logic [MS_W-1:0]    MAX_MS_RST = 16'd3000;
  localparam logic [RATIO_W-1:0] RATIO_RST  = 7'd90;

  typedef enum logic [2:0] {
    MODE_STARTUP     = 3'd0,
    MODE_IDLE        = 3'd1,
    MODE_PRECHARGING = 3'd2,
    MODE_ACTIVE      = 3'd3,
    MODE_ERROR       = 3'd4
  } mode_e;

  // One registered update, voltages already scaled for the ratio check
  typedef struct packed {
    logic              crit;
    logic              batt_ready;
    logic              sdc_active;
    logic [STEP_W-1:0] step_ms;
    logic [PROD_W-1:0] bus_scaled;
    logic [PROD_W-1:0] pack_scaled;
  } item_t;

  typedef struct packed {
    logic [MS_W-1:0]    min_ms;
    logic [MS_W-1:0]    max_ms;
    logic [RATIO_W-1:0] ratio_pct;
  } cfg_t;

endpackage

[hdl/hv_precharge_sequencer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hv_precharge_sequencer
// Contactor and precharge sequencer for a high-voltage battery pack.
// ----------------------------------------------------------------------------
// Each slave beat is one update (fault, battery ready, shutdown circuit,
// elapsed milliseconds, bus and pack voltage); each update yields exactly one
// master beat with the mode and relay/DC-DC enables after that update. The
// block takes one update per clock; each update passes the input register,
// which also forms bus*100 and pack*ratio, and then the result register,
// which doubles as the mode state, with the mode logic, the saturating
// precharge timer and the compares between the two. Back-pressure on the
// master side stalls the input register, so no beat is dropped. The
// precharge relay and positive relay are never closed together; once in
// error the block stays there until reset. Write the three timing/ratio
// registers on the cfg port only while no update is in flight.
// ----------------------------------------------------------------------------
module hv_precharge_sequencer import hps_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  // update beats
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [0] critical_error, [1] battery_ready, [2] shutdown_active,
  // [10:3] step_ms, [26:11] bus_voltage, [42:27] pack_voltage, [47:43] zero
  input  logic [47:0] s_axis_tdata,
  // result beats
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [2:0] mode, [3] dcdc_enabled, [4] precharge_relay_closed,
  // [5] positive_relay_closed, [6] precharge_timeout, [7] zero
  output logic [7:0]  m_axis_tdata
);

  cfg_t  cfg_q;
  logic  mid_valid;
  logic  mid_ready;
  item_t mid_item;
  logic [2:0] mode;
  logic  dcdc;
  logic  pc_closed;
  logic  pos_closed;
  logic  timeout;

  // configuration is always accepted; unknown indexes are dropped
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_ms    <= MIN_MS_RST;
      cfg_q.max_ms    <= MAX_MS_RST;
      cfg_q.ratio_pct <= RATIO_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_MIN_MS:    cfg_q.min_ms    <= cfg_data_i;
        CFG_MAX_MS:    cfg_q.max_ms    <= cfg_data_i;
        CFG_RATIO_PCT: cfg_q.ratio_pct <= cfg_data_i[RATIO_W-1:0];
        default: ;
      endcase
    end
  end

  // register the update and scale the voltages
  hps_in_stage u_in (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (s_axis_tvalid),
    .ready_o        (s_axis_tready),
    .crit_i         (s_axis_tdata[0]),
    .batt_ready_i   (s_axis_tdata[1]),
    .sdc_active_i   (s_axis_tdata[2]),
    .step_ms_i      (s_axis_tdata[10:3]),
    .bus_voltage_i  (s_axis_tdata[26:11]),
    .pack_voltage_i (s_axis_tdata[42:27]),
    .ratio_pct_i    (cfg_q.ratio_pct),
    .valid_o        (mid_valid),
    .ready_i        (mid_ready),
    .item_o         (mid_item)
  );

  // advance the mode and hold the result until taken
  hps_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .valid_i      (mid_valid),
    .ready_o      (mid_ready),
    .item_i       (mid_item),
    .valid_o      (m_axis_tvalid),
    .ready_i      (m_axis_tready),
    .mode_o       (mode),
    .dcdc_o       (dcdc),
    .pc_closed_o  (pc_closed),
    .pos_closed_o (pos_closed),
    .timeout_o    (timeout)
  );

  assign m_axis_tdata = {1'b0, timeout, pos_closed, pc_closed, dcdc, mode};

endmodule

[hdl/hps_in_stage.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hps_in_stage
// Input register: unpacks a beat and forms bus*100 and pack*ratio.
// ----------------------------------------------------------------------------
module hps_in_stage import hps_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  output logic                  ready_o,
  input  logic                  crit_i,
  input  logic                  batt_ready_i,
  input  logic                  sdc_active_i,
  input  logic [STEP_W-1:0]     step_ms_i,
  input  logic [VOLT_W-1:0]     bus_voltage_i,
  input  logic [VOLT_W-1:0]     pack_voltage_i,
  input  logic [RATIO_W-1:0]    ratio_pct_i,
  output logic                  valid_o,
  input  logic                  ready_i,
  output item_t                 item_o
);

  logic  valid_q;
  item_t item_q, item_d;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign item_o  = item_q;

  always_comb begin
    item_d.crit        = crit_i;
    item_d.batt_ready  = batt_ready_i;
    item_d.sdc_active  = sdc_active_i;
    item_d.step_ms     = step_ms_i;
    item_d.bus_scaled  = {{RATIO_W{1'b0}}, bus_voltage_i} *
                         {{VOLT_W{1'b0}}, PCT_SCALE};
    item_d.pack_scaled = {{RATIO_W{1'b0}}, pack_voltage_i} *
                         {{VOLT_W{1'b0}}, ratio_pct_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_d;
    end
  end

endmodule

[hdl/hps_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hps_core
// Mode state, precharge timer, relay enables and the result register.
// ----------------------------------------------------------------------------
module hps_core import hps_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        valid_i,
  output logic        ready_o,
  input  item_t       item_i,
  output logic        valid_o,
  input  logic        ready_i,
  output logic [2:0]  mode_o,
  output logic        dcdc_o,
  output logic        pc_closed_o,
  output logic        pos_closed_o,
  output logic        timeout_o
);

  mode_e           mode_q, mode_d;
  logic [MS_W-1:0] elapsed_q, elapsed_d;
  logic            dcdc_q, dcdc_d;
  logic            pc_q, pc_d;
  logic            pos_q, pos_d;
  logic            to_q, to_d;
  logic            out_valid_q;
  logic            take;
  logic [MS_W:0]   sum;
  logic [MS_W-1:0] t_new;

  assign ready_o = !out_valid_q || ready_i;
  assign take    = valid_i && ready_o;

  assign sum   = {1'b0, elapsed_q} + {{(MS_W + 1 - STEP_W){1'b0}}, item_i.step_ms};
  assign t_new = sum[MS_W] ? {MS_W{1'b1}} : sum[MS_W-1:0];

  always_comb begin
    mode_d    = mode_q;
    elapsed_d = elapsed_q;
    dcdc_d    = dcdc_q;
    pc_d      = pc_q;
    pos_d     = pos_q;
    to_d      = to_q;

    // critical error: drop into error before the mode handling runs
    if (item_i.crit) begin
      mode_d = MODE_ERROR;
      pc_d   = 1'b0;
      pos_d  = 1'b0;
      dcdc_d = 1'b0;
    end

    case (mode_d)
      MODE_STARTUP: begin
        if (item_i.batt_ready) begin
          mode_d = MODE_IDLE;
          dcdc_d = 1'b1;
          pc_d   = 1'b1;
          pos_d  = 1'b0;
        end
      end
      MODE_IDLE: begin
        if (!item_i.sdc_active) begin
          mode_d    = MODE_PRECHARGING;
          elapsed_d = '0;
        end
      end
      MODE_PRECHARGING: begin
        elapsed_d = t_new;
        if ((t_new > cfg_i.min_ms) && (item_i.bus_scaled > item_i.pack_scaled)) begin
          mode_d = MODE_ACTIVE;
          pos_d  = 1'b1;
          pc_d   = 1'b0;
        end else if (t_new > cfg_i.max_ms) begin
          to_d   = 1'b1;
          mode_d = MODE_ERROR;
          pc_d   = 1'b0;
          pos_d  = 1'b0;
          dcdc_d = 1'b0;
        end else if (item_i.sdc_active) begin
          mode_d = MODE_IDLE;
          dcdc_d = 1'b1;
          pc_d   = 1'b1;
          pos_d  = 1'b0;
        end
      end
      MODE_ACTIVE: begin
        if (item_i.sdc_active) begin
          mode_d = MODE_IDLE;
          dcdc_d = 1'b1;
          pc_d   = 1'b1;
          pos_d  = 1'b0;
        end
      end
      default: begin
        mode_d = MODE_ERROR;
        pc_d   = 1'b0;
        pos_d  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_STARTUP;
      elapsed_q   <= '0;
      dcdc_q      <= 1'b0;
      pc_q        <= 1'b0;
      pos_q       <= 1'b0;
      to_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (ready_o) begin
        out_valid_q <= valid_i;
      end
      if (take) begin
        mode_q    <= mode_d;
        elapsed_q <= elapsed_d;
        dcdc_q    <= dcdc_d;
        pc_q      <= pc_d;
        pos_q     <= pos_d;
        to_q      <= to_d;
      end
    end
  end

  // the state registers are the result register
  assign valid_o      = out_valid_q;
  assign mode_o       = mode_q;
  assign dcdc_o       = dcdc_q;
  assign pc_closed_o  = pc_q;
  assign pos_closed_o = pos_q;
  assign timeout_o    = to_q;

  a_relays_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pc_q && pos_q))
    else $error("precharge and positive relays closed together");

  a_error_safe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == MODE_ERROR) |-> (!pc_q && !pos_q && !dcdc_q))
    else $error("outputs not safe in error mode");

  a_error_absorbing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == MODE_ERROR) |=> (mode_q == MODE_ERROR))
    else $error("left error mode");

  a_timeout_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    to_q |=> to_q)
    else $error("timeout flag cleared");

  a_timeout_means_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(to_q) |-> (mode_q == MODE_ERROR))
    else $error("timeout raised outside error mode");

endmodule
